FILE: design/sre_pkg.sv
// ----------------------------------------------------------------------------
// sre_pkg: shared types and codes of the register machine execute block
// Item and result layouts, the decoded command that sits between the front
// and back parts, op codes and condition codes.
// ----------------------------------------------------------------------------
package sre_pkg;

  localparam logic [3:0] OP_STORE = 4'd1;
  localparam logic [3:0] OP_LOAD  = 4'd2;
  localparam logic [3:0] OP_ADD   = 4'd3;
  localparam logic [3:0] OP_SUB   = 4'd4;
  localparam logic [3:0] OP_MUL   = 4'd5;
  localparam logic [3:0] OP_JUMP  = 4'd6;
  localparam logic [3:0] OP_IF    = 4'd7;
  localparam logic [3:0] OP_PRINT = 4'd13;
  localparam logic [3:0] OP_READ  = 4'd14;

  localparam logic [3:0] CC_EQ   = 4'd8;
  localparam logic [3:0] CC_LT   = 4'd9;
  localparam logic [3:0] CC_GT   = 4'd10;
  localparam logic [3:0] CC_LTEQ = 4'd11;
  localparam logic [3:0] CC_GTEQ = 4'd12;

  localparam logic CMD_EXECUTE    = 1'b0;
  localparam logic CMD_LOAD_CONST = 1'b1;

  localparam int unsigned CMD_QUEUE_DEPTH = 2;
  localparam int unsigned RES_QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    KIND_NOP,
    KIND_LDC,
    KIND_STORE,
    KIND_LOAD,
    KIND_ADD,
    KIND_SUB,
    KIND_MUL,
    KIND_IF,
    KIND_PRINT,
    KIND_READ
  } kind_e;

  typedef struct packed {
    logic               command;
    logic [3:0]         op_code;
    logic [9:0]         first_operand;
    logic [9:0]         second_operand;
    logic [3:0]         third_operand;
    logic [10:0]        false_target;
    logic [9:0]         current_index;
    logic signed [31:0] supplied_value;
  } in_item_t;

  typedef struct packed {
    logic [10:0]        next_index;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               print_is_constant;
  } out_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [9:0]  ra;
    logic        ra_ok;
    logic [9:0]  rb;
    logic        rb_ok;
    logic [9:0]  wr_reg;
    logic        wr_ok;
    logic [9:0]  addr;
    logic        addr_ok;
    logic [3:0]  cond;
    logic [10:0] next_index;
    logic [10:0] fail_index;
    logic [31:0] value;
  } cmd_t;

endpackage

FILE: design/sre_fifo.sv
// ----------------------------------------------------------------------------
// sre_fifo: small synchronous queue
// Register based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module sre_fifo #(
  parameter int unsigned Depth = 2,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/sre_front.sv
// ----------------------------------------------------------------------------
// sre_front: input acceptance and instruction classification
// Takes items from the input port, decodes the operation, range checks the
// register and store operands and works out the fall-through and branch
// indexes before the command enters the command queue.
// ----------------------------------------------------------------------------
module sre_front #(
  parameter int unsigned STORE_DEPTH    = 1024,
  parameter int unsigned REGISTER_COUNT = 8
) (
  input  sre_pkg::in_item_t item_i,
  input  logic              push_i,
  output logic              full_o,
  input  logic              queue_full_i,
  input  logic              busy_i,
  output sre_pkg::cmd_t     cmd_o,
  output logic              cmd_push_o
);

  import sre_pkg::*;

  logic [9:0]  op_a, op_b, op_c;
  logic        a_reg_ok, b_reg_ok, c_reg_ok;
  logic        a_mem_ok, b_mem_ok;
  logic [10:0] seq_index, jump_index, fail_index;

  assign full_o     = queue_full_i || busy_i;
  assign cmd_push_o = push_i && !full_o;

  assign op_a = item_i.first_operand;
  assign op_b = item_i.second_operand;
  assign op_c = {6'b0, item_i.third_operand};

  assign a_reg_ok = ({22'b0, op_a} < 32'(REGISTER_COUNT));
  assign b_reg_ok = ({22'b0, op_b} < 32'(REGISTER_COUNT));
  assign c_reg_ok = ({22'b0, op_c} < 32'(REGISTER_COUNT));
  assign a_mem_ok = ({22'b0, op_a} < 32'(STORE_DEPTH));
  assign b_mem_ok = ({22'b0, op_b} < 32'(STORE_DEPTH));

  assign seq_index  = {1'b0, item_i.current_index} + 11'd1;
  assign jump_index = (op_a == '0) ? '0 : {1'b0, op_a} - 11'd1;
  assign fail_index = (item_i.false_target == '0) ? '0 : item_i.false_target - 11'd1;

  always_comb begin
    cmd_o            = '0;
    cmd_o.kind       = KIND_NOP;
    cmd_o.wr_reg     = op_a;
    cmd_o.wr_ok      = a_reg_ok;
    cmd_o.cond       = item_i.third_operand;
    cmd_o.next_index = seq_index;
    cmd_o.fail_index = fail_index;
    cmd_o.value      = item_i.supplied_value;
    if (item_i.command == CMD_LOAD_CONST) begin
      cmd_o.kind       = KIND_LDC;
      cmd_o.addr       = op_a;
      cmd_o.addr_ok    = a_mem_ok;
      cmd_o.next_index = {1'b0, item_i.current_index};
    end else begin
      case (item_i.op_code)
        OP_STORE: begin
          cmd_o.kind    = KIND_STORE;
          cmd_o.ra      = op_b;
          cmd_o.ra_ok   = b_reg_ok;
          cmd_o.addr    = op_a;
          cmd_o.addr_ok = a_mem_ok;
        end
        OP_LOAD: begin
          cmd_o.kind    = KIND_LOAD;
          cmd_o.addr    = op_b;
          cmd_o.addr_ok = b_mem_ok;
        end
        OP_ADD, OP_SUB, OP_MUL: begin
          cmd_o.kind  = (item_i.op_code == OP_ADD) ? KIND_ADD :
                        (item_i.op_code == OP_SUB) ? KIND_SUB : KIND_MUL;
          cmd_o.ra    = op_b;
          cmd_o.ra_ok = b_reg_ok;
          cmd_o.rb    = op_c;
          cmd_o.rb_ok = c_reg_ok;
        end
        OP_JUMP: begin
          cmd_o.next_index = jump_index;
        end
        OP_IF: begin
          cmd_o.kind  = KIND_IF;
          cmd_o.ra    = op_a;
          cmd_o.ra_ok = a_reg_ok;
          cmd_o.rb    = op_b;
          cmd_o.rb_ok = b_reg_ok;
        end
        OP_PRINT: begin
          cmd_o.kind    = KIND_PRINT;
          cmd_o.ra      = op_a;
          cmd_o.ra_ok   = a_reg_ok;
          cmd_o.addr    = op_a;
          cmd_o.addr_ok = a_mem_ok;
        end
        OP_READ: begin
          cmd_o.kind = KIND_READ;
        end
        default: begin
          cmd_o.kind = KIND_NOP;
        end
      endcase
    end
  end

endmodule

FILE: design/sre_back.sv
// ----------------------------------------------------------------------------
// sre_back: execution part
// Issues one command at a time: an issue step reads the register file and
// the stores into registers, an execute step computes, writes back and
// pushes the result. Also runs the constant mark clearing pass after reset.
// ----------------------------------------------------------------------------
module sre_back #(
  parameter int unsigned STORE_DEPTH    = 1024,
  parameter int unsigned REGISTER_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sre_pkg::cmd_t      cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  output sre_pkg::out_item_t res_o,
  output logic               res_push_o,
  input  logic               res_full_i,
  output logic               busy_o
);

  import sre_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned RW = $clog2(REGISTER_COUNT);

  logic [31:0] rf_mem    [REGISTER_COUNT];
  logic [31:0] var_mem   [STORE_DEPTH];
  logic [31:0] const_mem [STORE_DEPTH];
  logic        mark_mem  [STORE_DEPTH];

  logic          ex_valid_q, ex_valid_d;
  cmd_t          ex_cmd_q;
  logic [31:0]   rda_q, rdb_q, var_q, const_q;
  logic          mark_q;
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  logic          issue, finish;
  logic [AW-1:0] rd_idx, ex_idx, mark_widx;
  logic          var_we, const_we, mark_we, mark_wd;
  logic [RW-1:0] ra_idx, rb_idx, wr_idx;
  logic          rf_we;
  logic [31:0]   wr_data, x, y, load_val, product;
  logic          mark_hit, fail;

  assign issue     = cmd_valid_i && !ex_valid_q && !clr_busy_q;
  assign finish    = ex_valid_q && !res_full_i;
  assign cmd_pop_o = issue;
  assign busy_o    = clr_busy_q;

  assign rd_idx = AW'(cmd_i.addr);
  assign ex_idx = AW'(ex_cmd_q.addr);
  assign ra_idx = RW'(cmd_i.ra);
  assign rb_idx = RW'(cmd_i.rb);
  assign wr_idx = RW'(ex_cmd_q.wr_reg);

  // execute
  assign x        = ex_cmd_q.ra_ok ? rda_q : '0;
  assign y        = ex_cmd_q.rb_ok ? rdb_q : '0;
  assign product  = x * y;
  assign mark_hit = ex_cmd_q.addr_ok && mark_q;
  assign load_val = mark_hit ? const_q : (ex_cmd_q.addr_ok ? var_q : '0);

  always_comb begin
    fail = 1'b0;
    case (ex_cmd_q.cond)
      CC_EQ:   fail = (x != y);
      CC_LT:   fail = ($signed(x) >= $signed(y));
      CC_GT:   fail = ($signed(x) <= $signed(y));
      CC_LTEQ: fail = ($signed(x) > $signed(y));
      CC_GTEQ: fail = ($signed(x) < $signed(y));
      default: fail = 1'b0;
    endcase
  end

  always_comb begin
    wr_data = ex_cmd_q.value;
    rf_we   = 1'b0;
    res_o   = '0;
    res_o.next_index = ex_cmd_q.next_index;
    case (ex_cmd_q.kind)
      KIND_LOAD: begin
        wr_data = load_val;
        rf_we   = 1'b1;
      end
      KIND_ADD: begin
        wr_data = x + y;
        rf_we   = 1'b1;
      end
      KIND_SUB: begin
        wr_data = x - y;
        rf_we   = 1'b1;
      end
      KIND_MUL: begin
        wr_data = product;
        rf_we   = 1'b1;
      end
      KIND_READ: begin
        rf_we = 1'b1;
      end
      KIND_IF: begin
        if (fail) begin
          res_o.next_index = ex_cmd_q.fail_index;
        end
      end
      KIND_PRINT: begin
        res_o.print_valid       = 1'b1;
        res_o.print_value       = mark_hit ? const_q : x;
        res_o.print_is_constant = mark_hit;
      end
      default: begin
        rf_we = 1'b0;
      end
    endcase
    rf_we = rf_we && finish && ex_cmd_q.wr_ok;
  end

  assign res_push_o = finish;

  assign var_we    = finish && (ex_cmd_q.kind == KIND_STORE) && ex_cmd_q.addr_ok;
  assign const_we  = finish && (ex_cmd_q.kind == KIND_LDC) && ex_cmd_q.addr_ok;
  assign mark_we   = clr_busy_q || const_we;
  assign mark_widx = clr_busy_q ? clr_cnt_q : ex_idx;
  assign mark_wd   = !clr_busy_q;

  // control
  always_comb begin
    ex_valid_d = ex_valid_q;
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (finish) begin
      ex_valid_d = 1'b0;
    end
    if (issue) begin
      ex_valid_d = 1'b1;
    end
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(STORE_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      ex_valid_q <= ex_valid_d;
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      ex_cmd_q <= cmd_i;
    end
  end

  // register file, two read ports
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rda_q <= rf_mem[ra_idx];
      rdb_q <= rf_mem[rb_idx];
    end
    if (rf_we) begin
      rf_mem[wr_idx] <= wr_data;
    end
  end

  // variable store
  always_ff @(posedge clk_i) begin
    if (issue) begin
      var_q <= var_mem[rd_idx];
    end
    if (var_we) begin
      var_mem[ex_idx] <= x;
    end
  end

  // constant store
  always_ff @(posedge clk_i) begin
    if (issue) begin
      const_q <= const_mem[rd_idx];
    end
    if (const_we) begin
      const_mem[ex_idx] <= ex_cmd_q.value;
    end
  end

  // constant marks
  always_ff @(posedge clk_i) begin
    if (issue) begin
      mark_q <= mark_mem[rd_idx];
    end
    if (mark_we) begin
      mark_mem[mark_widx] <= mark_wd;
    end
  end

endmodule

FILE: design/small_register_machine_execute.sv
// ----------------------------------------------------------------------------
// small_register_machine_execute: instruction execute block
// Executes decoded instructions and load-constant commands of a small
// register machine and returns the next instruction index and any print.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  item      in         push / full        in_item_i  (sre_pkg::in_item_t)
//  result    out        pop / empty        out_item_o (sre_pkg::out_item_t)
//
// in the execute unit an item first reads the register file and stores, then
// computes and writes back; the unit takes the next item only after that
// the front takes one item per cycle, while full is low, into a two-entry
// command queue; after reset all constant marks are cleared, with full high
// results wait in a two-entry result queue; a stalled pop stalls execute,
// then full rises once the command queue fills
// ----------------------------------------------------------------------------
module small_register_machine_execute #(
  parameter int unsigned STORE_DEPTH    = 1024,
  parameter int unsigned REGISTER_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  sre_pkg::in_item_t  in_item_i,
  input  logic               pop,
  output logic               empty,
  output sre_pkg::out_item_t out_item_o
);

  import sre_pkg::*;

  cmd_t      front_cmd, queue_cmd;
  logic      front_push, queue_full, queue_empty, queue_pop;
  out_item_t back_res;
  logic      back_push, res_full, back_busy;

  sre_front #(
    .STORE_DEPTH    (STORE_DEPTH),
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_front (
    .item_i       (in_item_i),
    .push_i       (push),
    .full_o       (full),
    .queue_full_i (queue_full),
    .busy_i       (back_busy),
    .cmd_o        (front_cmd),
    .cmd_push_o   (front_push)
  );

  sre_fifo #(
    .Depth  (CMD_QUEUE_DEPTH),
    .item_t (cmd_t)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .data_o  (queue_cmd),
    .empty_o (queue_empty)
  );

  sre_back #(
    .STORE_DEPTH    (STORE_DEPTH),
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (!queue_empty),
    .cmd_pop_o   (queue_pop),
    .res_o       (back_res),
    .res_push_o  (back_push),
    .res_full_i  (res_full),
    .busy_o      (back_busy)
  );

  sre_fifo #(
    .Depth  (RES_QUEUE_DEPTH),
    .item_t (out_item_t)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

FILE: tb/tb_small_register_machine_execute.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_small_register_machine_execute: self-checking bench of the execute block
// Instructions and load-constant commands go in through the push side, and
// each result is checked against a predictor of the register machine kept in
// the bench. The run has a directed part, a stretch where results are held
// back until the input stalls, and a long random part. Both sides idle at
// random, but for the first 300 items of the random part.
// ----------------------------------------------------------------------------
module tb_small_register_machine_execute;
  import sre_pkg::*;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned REG_COUNT   = 8;
  localparam int unsigned REG_W       = $clog2(REG_COUNT);
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [3:0] OP_ENDIF       = 4'd15;
  localparam logic [3:0] OP_SPARE_FIRST = 4'd8;
  localparam logic [3:0] OP_SPARE_LAST  = 4'd12;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push;
  logic      full;
  logic      pop;
  logic      empty;
  in_item_t  in_item;
  out_item_t out_item;

  // predictor state
  logic [31:0] reg_file [REG_COUNT];
  logic [31:0] var_mem [STORE_DEPTH];
  logic [31:0] const_mem [STORE_DEPTH];
  bit          const_mark [STORE_DEPTH];

  // what the stimulus has already written, so that no unwritten entry is read
  bit          reg_ready [REG_COUNT];
  bit          addr_ready [STORE_DEPTH];
  bit          gen_marked [STORE_DEPTH];
  logic [9:0]  load_addrs [$];

  in_item_t    pending_instrs [$];
  out_item_t   expected_results [$];

  bit          send_idle_en;
  bit          recv_idle_en;
  int unsigned pop_hold_cycles;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned instrs_accepted;
  int unsigned results_checked;
  int unsigned prints_checked;
  int unsigned if_fails_predicted;

  small_register_machine_execute #(
    .STORE_DEPTH   (STORE_DEPTH),
    .REGISTER_COUNT(REG_COUNT)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item),
    .pop       (pop),
    .empty     (empty),
    .out_item_o(out_item)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               expected_results.size());
      $display("[small_register_machine_execute] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] reg_value(logic [9:0] idx);
    return (idx < REG_COUNT) ? reg_file[REG_W'(idx)] : 32'd0;
  endfunction

  function automatic void write_reg(logic [9:0] idx, logic [31:0] v);
    if (idx < REG_COUNT) reg_file[REG_W'(idx)] = v;
  endfunction

  function automatic logic [10:0] target_index(logic [10:0] t);
    return (t == 11'd0) ? 11'd0 : t - 11'd1;
  endfunction

  function automatic out_item_t execute_instr(in_item_t it);
    out_item_t          r;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    bit                 fail;
    logic [9:0]         a;
    logic [9:0]         b;
    logic [9:0]         c;
    a = it.first_operand;
    b = it.second_operand;
    c = {6'd0, it.third_operand};
    r = '0;
    r.next_index = {1'b0, it.current_index} + 11'd1;
    if (it.command == CMD_LOAD_CONST) begin
      const_mem[a] = it.supplied_value;
      const_mark[a] = 1'b1;
      r.next_index = {1'b0, it.current_index};
    end else begin
      case (it.op_code)
        OP_STORE: var_mem[a] = reg_value(b);
        OP_LOAD:  write_reg(a, const_mark[b] ? const_mem[b] : var_mem[b]);
        OP_ADD:   write_reg(a, reg_value(b) + reg_value(c));
        OP_SUB:   write_reg(a, reg_value(b) - reg_value(c));
        OP_MUL:   write_reg(a, reg_value(b) * reg_value(c));
        OP_JUMP:  r.next_index = target_index({1'b0, a});
        OP_IF: begin
          sx = reg_value(a);
          sy = reg_value(b);
          case (it.third_operand)
            CC_EQ:   fail = (sx != sy);
            CC_LT:   fail = (sx >= sy);
            CC_GT:   fail = (sx <= sy);
            CC_LTEQ: fail = (sx > sy);
            CC_GTEQ: fail = (sx < sy);
            default: fail = 1'b0;
          endcase
          if (fail) begin
            r.next_index = target_index(it.false_target);
            if_fails_predicted++;
          end
        end
        OP_PRINT: begin
          r.print_valid = 1'b1;
          if (const_mark[a]) begin
            r.print_value = const_mem[a];
            r.print_is_constant = 1'b1;
          end else begin
            r.print_value = reg_value(a);
          end
        end
        OP_READ: write_reg(a, it.supplied_value);
        default: ;
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [9:0] readable_reg(logic [9:0] idx);
    if (idx >= REG_COUNT || reg_ready[REG_W'(idx)]) return idx;
    return 10'(REG_COUNT + idx % 5);
  endfunction

  function automatic void note_addr(logic [9:0] a);
    if (!addr_ready[a]) begin
      addr_ready[a] = 1'b1;
      load_addrs.push_back(a);
    end
  endfunction

  function automatic in_item_t make_instr(logic cmd, logic [3:0] op, logic [9:0] a,
                                          logic [9:0] b, logic [3:0] c, logic [10:0] ft,
                                          logic [9:0] cur, logic [31:0] val);
    in_item_t it;
    it.command        = cmd;
    it.op_code        = op;
    it.first_operand  = a;
    it.second_operand = b;
    it.third_operand  = c;
    it.false_target   = ft;
    it.current_index  = cur;
    it.supplied_value = val;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          default: return 32'd0;
        endcase
      end
      1, 2:    return 32'($urandom_range(8)) - 32'd4;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [9:0] rand_reg();
    return ($urandom_range(99) < 88) ? 10'($urandom_range(REG_COUNT - 1))
                                     : 10'($urandom_range(STORE_DEPTH - 1));
  endfunction

  function automatic logic [9:0] rand_addr();
    if (load_addrs.size() > 0 && $urandom_range(99) < 80)
      return load_addrs[$urandom_range(load_addrs.size() - 1)];
    return 10'($urandom_range(STORE_DEPTH - 1));
  endfunction

  function automatic in_item_t random_instr();
    in_item_t    it;
    int unsigned pick;
    it = make_instr(CMD_EXECUTE, OP_ENDIF, 10'($urandom()), 10'($urandom()),
                    4'($urandom_range(12)), 11'($urandom_range(1024)),
                    10'($urandom()), $urandom());
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.command = CMD_LOAD_CONST;
      it.supplied_value = rand_value();
    end else if (pick < 14) begin
      it.op_code = OP_STORE;
      it.second_operand = rand_reg();
    end else if (pick < 26) begin
      it.op_code = OP_LOAD;
      it.first_operand = rand_reg();
      it.second_operand = rand_addr();
    end else if (pick < 52) begin
      it.op_code = (pick < 36) ? OP_ADD : (pick < 44) ? OP_SUB : OP_MUL;
      it.first_operand = rand_reg();
      it.second_operand = rand_reg();
      it.third_operand = ($urandom_range(9) == 0) ? 4'($urandom_range(CC_EQ, CC_GTEQ))
                                                  : 4'($urandom_range(REG_COUNT - 1));
    end else if (pick < 58) begin
      it.op_code = OP_JUMP;
    end else if (pick < 74) begin
      it.op_code = OP_IF;
      it.first_operand = rand_reg();
      it.second_operand = ($urandom_range(3) == 0) ? it.first_operand : rand_reg();
      it.third_operand = ($urandom_range(9) == 0) ? 4'($urandom_range(REG_COUNT - 1))
                                                  : 4'($urandom_range(CC_EQ, CC_GTEQ));
    end else if (pick < 82) begin
      it.op_code = OP_PRINT;
      case ($urandom_range(4))
        0, 1:    it.first_operand = 10'($urandom_range(REG_COUNT - 1));
        2, 3:    it.first_operand = rand_addr();
        default: ;
      endcase
    end else if (pick < 92) begin
      it.op_code = OP_READ;
      it.first_operand = rand_reg();
      it.supplied_value = rand_value();
    end else if (pick < 95) begin
      it.op_code = OP_ENDIF;
    end else begin
      it.op_code = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end
    return it;
  endfunction

  // keeps reads off unwritten entries, then queues the item for the driver
  task automatic send_instr(input in_item_t it);
    logic [9:0] a;
    if (it.command == CMD_EXECUTE) begin
      case (it.op_code)
        OP_STORE: it.second_operand = readable_reg(it.second_operand);
        OP_LOAD: begin
          if (!addr_ready[it.second_operand]) begin
            if (load_addrs.size() > 0)
              it.second_operand = load_addrs[$urandom_range(load_addrs.size() - 1)];
            else
              it.op_code = OP_READ;
          end
        end
        OP_ADD, OP_SUB, OP_MUL: begin
          it.second_operand = readable_reg(it.second_operand);
          it.third_operand = 4'(readable_reg({6'd0, it.third_operand}));
        end
        OP_IF: begin
          it.first_operand = readable_reg(it.first_operand);
          it.second_operand = readable_reg(it.second_operand);
        end
        OP_PRINT: begin
          if (!gen_marked[it.first_operand])
            it.first_operand = readable_reg(it.first_operand);
        end
        default: ;
      endcase
    end
    a = it.first_operand;
    if (it.command == CMD_LOAD_CONST) begin
      gen_marked[a] = 1'b1;
      note_addr(a);
    end else begin
      case (it.op_code)
        OP_STORE: note_addr(a);
        OP_LOAD, OP_ADD, OP_SUB, OP_MUL, OP_READ:
          if (a < REG_COUNT) reg_ready[REG_W'(a)] = 1'b1;
        default: ;
      endcase
    end
    while (pending_instrs.size() >= 2) @(posedge clk_i);
    pending_instrs.push_back(it);
  endtask

  // input side: one transfer per edge at most, next item offered right after
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        expected_results.push_back(execute_instr(in_item));
        instrs_accepted++;
      end
      if (!push || !full) begin
        if (pending_instrs.size() > 0 && !(send_idle_en && $urandom_range(99) < 6)) begin
          push <= 1'b1;
          in_item <= pending_instrs.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("unexpected result: next %0d print %0b value %h const %0b",
                 got.next_index, got.print_valid, got.print_value, got.print_is_constant);
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (want.print_valid) prints_checked++;
    if (got.next_index !== want.next_index || got.print_valid !== want.print_valid ||
        got.print_value !== want.print_value ||
        got.print_is_constant !== want.print_is_constant) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("mismatch on result %0d: expected next %0d print %0b/%h/%0b, got %0d %0b/%h/%0b",
                 results_checked, want.next_index, want.print_valid, want.print_value,
                 want.print_is_constant, got.next_index, got.print_valid, got.print_value,
                 got.print_is_constant);
    end
  endtask

  // result side: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_result(out_item);
      if (pop_hold_cycles > 0) begin
        pop_hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= !(recv_idle_en && $urandom_range(99) < 6);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_register_reads();
    send_instr(make_instr(CMD_EXECUTE, OP_READ, 10'd0, 10'd0, 4'd0, 11'd0, 10'd0,
                          32'h7fff_ffff));
    send_instr(make_instr(CMD_EXECUTE, OP_READ, 10'd1, 10'd0, 4'd0, 11'd0, 10'd1,
                          32'h8000_0000));
    send_instr(make_instr(CMD_EXECUTE, OP_READ, 10'd2, 10'd0, 4'd0, 11'd0, 10'd2,
                          32'hffff_ffff));
    send_instr(make_instr(CMD_EXECUTE, OP_READ, 10'd3, 10'd0, 4'd0, 11'd0, 10'd3, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_READ, 10'd4, 10'd0, 4'd0, 11'd0, 10'd4, 32'd1));
    send_instr(make_instr(CMD_EXECUTE, OP_READ, 10'd5, 10'd0, 4'd0, 11'd0, 10'd5, 32'd5));
    send_instr(make_instr(CMD_EXECUTE, OP_READ, 10'd6, 10'd0, 4'd0, 11'd0, 10'd6, 32'd5));
    send_instr(make_instr(CMD_EXECUTE, OP_READ, 10'd7, 10'd0, 4'd0, 11'd0, 10'd1023,
                          -32'sd7));
  endtask

  task automatic test_memory();
    send_instr(make_instr(CMD_LOAD_CONST, OP_ENDIF, 10'd0, 10'd0, 4'd0, 11'd0, 10'd8,
                          32'h1234_5678));
    send_instr(make_instr(CMD_LOAD_CONST, OP_ENDIF, 10'd1023, 10'd1023, 4'd12, 11'd1024,
                          10'd1023, 32'h8000_0000));
    send_instr(make_instr(CMD_EXECUTE, OP_STORE, 10'd5, 10'd1, 4'd0, 11'd0, 10'd9, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_LOAD, 10'd3, 10'd5, 4'd0, 11'd0, 10'd10, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_LOAD, 10'd4, 10'd1023, 4'd0, 11'd0, 10'd11, 32'd0));
  endtask

  task automatic test_arithmetic();
    send_instr(make_instr(CMD_EXECUTE, OP_SUB, 10'd6, 10'd1, 4'd0, 11'd0, 10'd12, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_MUL, 10'd7, 10'd0, 4'd1, 11'd0, 10'd13, 32'd0));
    // out-of-range destination and source
    send_instr(make_instr(CMD_EXECUTE, OP_ADD, 10'd1023, 10'd0, 4'd12, 11'd0, 10'd14, 32'd0));
  endtask

  task automatic test_control_flow();
    send_instr(make_instr(CMD_EXECUTE, OP_JUMP, 10'd0, 10'd0, 4'd0, 11'd0, 10'd15, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_JUMP, 10'd1023, 10'd0, 4'd0, 11'd0, 10'd16, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_IF, 10'd5, 10'd3, CC_EQ, 11'd1024, 10'd17, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_IF, 10'd0, 10'd1, CC_LT, 11'd1024, 10'd18, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_IF, 10'd0, 10'd1, CC_GT, 11'd1, 10'd19, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_IF, 10'd0, 10'd1, CC_LTEQ, 11'd0, 10'd20, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_IF, 10'd2, 10'd3, CC_GTEQ, 11'd700, 10'd21, 32'd0));
    // unknown condition falls through
    send_instr(make_instr(CMD_EXECUTE, OP_IF, 10'd0, 10'd1, 4'd3, 11'd400, 10'd22, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_ENDIF, 10'd0, 10'd0, 4'd0, 11'd0, 10'd23, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_SPARE_FIRST, 10'd1, 10'd2, 4'd3, 11'd9, 10'd24,
                          32'd0));
  endtask

  task automatic test_print();
    send_instr(make_instr(CMD_EXECUTE, OP_PRINT, 10'd0, 10'd0, 4'd0, 11'd0, 10'd25, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_PRINT, 10'd2, 10'd0, 4'd0, 11'd0, 10'd26, 32'd0));
    send_instr(make_instr(CMD_EXECUTE, OP_PRINT, 10'd500, 10'd0, 4'd0, 11'd0, 10'd27, 32'd0));
  endtask

  task automatic test_result_backpressure();
    pop_hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_instr(random_instr());
  endtask

  task automatic test_random_program(input int unsigned count);
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == 300) begin
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
      end
      send_instr(random_instr());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_item = '0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reads();
    test_memory();
    test_arithmetic();
    test_control_flow();
    test_print();
    test_result_backpressure();
    test_random_program(1480);

    while (pending_instrs.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d instructions in %0d cycles: %0d results checked, %0d prints,",
             instrs_accepted, cycle_count, results_checked, prints_checked);
    $display("%0d failed IF conditions, %0d load addresses in use, %0d failures",
             if_fails_predicted, load_addrs.size(), fail_count);
    if (fail_count == 0) begin
      $display("[small_register_machine_execute] OK");
    end else begin
      $display("[small_register_machine_execute] ERROR");
    end
    $finish;
  end

endmodule
